[rtl/core/pft_pkg.sv]
// Shared types, sizes and the quarter-wave sine table for the planar frame transform.
package pft_pkg;

  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int TRIG_DEPTH = 1024;

  // table depth rounded down to a power of two
  localparam int TRIG_LOG2  = $clog2(TRIG_DEPTH + 1) - 1;
  localparam int TRIG_SIZE  = 1 << TRIG_LOG2;
  localparam int PHASE_BITS = TRIG_LOG2 + 2;

  localparam int TRIG_FRAC  = 15;
  localparam int TRIG_W     = TRIG_FRAC + 1;
  localparam int TRIG_ONE   = (1 << TRIG_FRAC) - 1;

  localparam logic [63:0] PI_Q61 = 64'd7244019458077122842;

  typedef enum logic {
    OP_TO_VEHICLE = 1'b0,
    OP_TO_GLOBAL  = 1'b1
  } pft_op_e;

  typedef struct packed {
    pft_op_e                       opcode;
    logic [ANGLE_BITS-1:0]         heading;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic signed [COORD_BITS-1:0]  point_z;
    logic signed [COORD_BITS-1:0]  origin_x;
    logic signed [COORD_BITS-1:0]  origin_y;
    logic signed [COORD_BITS-1:0]  origin_z;
  } pft_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  result_x;
    logic signed [COORD_BITS-1:0]  result_y;
    logic signed [COORD_BITS-1:0]  result_z;
    logic                          clipped;
  } pft_rsp_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } pft_trig_t;

  typedef logic [TRIG_FRAC-1:0] pft_sin_tab_t [TRIG_SIZE];

  // (a * b) >> sh, low 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  // Taylor series, angle and result in Q3.61
  function automatic logic [63:0] sin_q61(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_shr(x, x, 61);
    term = x;
    sum  = x;
    for (int n = 1; n <= 25; n++) begin
      term = mul_shr(term, x2, 61) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic pft_sin_tab_t build_sin_tab();
    pft_sin_tab_t tab;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  x;
    logic [63:0]  v;
    q = (PI_Q61 >> 1) >> TRIG_LOG2;
    r = (PI_Q61 >> 1) & 64'(TRIG_SIZE - 1);
    for (int i = 0; i < TRIG_SIZE; i++) begin
      x = q * 64'(i) + ((r * 64'(i)) >> TRIG_LOG2);
      v = mul_shr(sin_q61(x), 64'(TRIG_ONE), 60);
      tab[i] = TRIG_FRAC'((v + 64'd1) >> 1);
    end
    return tab;
  endfunction

  localparam pft_sin_tab_t SIN_TAB = build_sin_tab();

endpackage

[rtl/core/pft_trig.sv]
// Sine and cosine lookup from the quarter-wave table with quadrant folding.
module pft_trig import pft_pkg::*; (
  input  logic [PHASE_BITS-1:0] phase_i,
  output pft_trig_t             trig_o
);

  function automatic logic signed [TRIG_W-1:0] lookup(logic [PHASE_BITS-1:0] ph);
    logic [1:0]              quad;
    logic [TRIG_LOG2-1:0]    idx;
    logic [TRIG_LOG2:0]      k;
    logic [TRIG_W-1:0]       mag;
    quad = ph[PHASE_BITS-1 -: 2];
    idx  = ph[TRIG_LOG2-1:0];
    // odd quadrants run the table backwards
    k    = quad[0] ? ((TRIG_LOG2+1)'(TRIG_SIZE) - {1'b0, idx}) : {1'b0, idx};
    // k equal to the depth is the peak
    mag  = k[TRIG_LOG2] ? TRIG_W'(TRIG_ONE) : {1'b0, SIN_TAB[k[TRIG_LOG2-1:0]]};
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  logic [PHASE_BITS-1:0] cos_phase;

  assign cos_phase    = phase_i + PHASE_BITS'(TRIG_SIZE);
  assign trig_o.sin_v = lookup(phase_i);
  assign trig_o.cos_v = lookup(cos_phase);

endmodule

[rtl/core/planar_frame_transform.sv]
// Top level: four-stage pipelined 2D rigid-body transform with z shift and saturation.
//
//   port group     dir  payload      handshake
//   in_*           in   pft_req_t    in_valid_i / in_stall_o
//   out_*          out  pft_rsp_t    out_valid_o / out_stall_i
//
// One request per cycle while in_stall_o is low; the result is registered at the end of each stage.
// Stages: angle lookup and origin offset, four 33x16 multipliers, sums, saturation.
// Reset clears only the stage valid bits.
// Each stage takes a new request when empty or moving on, so bubbles are squeezed out;
// in_stall_o rises only when all four stages hold requests and out_stall_i is high.
module planar_frame_transform import pft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pft_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pft_rsp_t out_data_o
);

  localparam int STAGES  = 4;
  localparam int VEC_W   = COORD_BITS + 1;        // difference at full width
  localparam int PROD_W  = VEC_W + TRIG_W;
  localparam int P_W     = VEC_W + 1;             // rounded product
  localparam int SUM_W   = P_W + 2;
  localparam int PH_DROP = (ANGLE_BITS >= PHASE_BITS) ? ANGLE_BITS - PHASE_BITS : 0;
  localparam int PH_ADD  = (ANGLE_BITS >= PHASE_BITS) ? 0 : PHASE_BITS - ANGLE_BITS;
  localparam int PH_W    = ANGLE_BITS + PHASE_BITS;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (TRIG_FRAC - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MAX =
    {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SAT_MIN = ~SAT_MAX;

  function automatic logic signed [P_W-1:0] rmul(logic signed [VEC_W-1:0] v,
                                                 logic signed [TRIG_W-1:0] t);
    logic signed [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(t);
    return P_W'((prod + ROUND_HALF) >>> TRIG_FRAC);
  endfunction

  // {clip, value}
  function automatic logic [COORD_BITS:0] saturate(logic signed [SUM_W-1:0] v);
    logic [COORD_BITS:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, SAT_MAX[COORD_BITS-1:0]};
    end else if (v < SAT_MIN) begin
      res = {1'b1, SAT_MIN[COORD_BITS-1:0]};
    end else begin
      res = {1'b0, v[COORD_BITS-1:0]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- flow control
  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[STAGES-1];

  // ---------------------------------------------------------------- stage 1
  logic [PHASE_BITS-1:0]      phase;
  pft_trig_t                  trig;
  logic signed [VEC_W-1:0]    vx_d, vy_d, vz_d;
  logic signed [COORD_BITS-1:0] ax_d, ay_d;

  assign phase = PHASE_BITS'((PH_W'(in_data_i.heading) << PH_ADD) >> PH_DROP);

  pft_trig u_trig (
    .phase_i (phase),
    .trig_o  (trig)
  );

  always_comb begin
    unique case (in_data_i.opcode)
      OP_TO_VEHICLE: begin
        vx_d = VEC_W'(in_data_i.point_x) - VEC_W'(in_data_i.origin_x);
        vy_d = VEC_W'(in_data_i.point_y) - VEC_W'(in_data_i.origin_y);
        vz_d = VEC_W'(in_data_i.point_z) - VEC_W'(in_data_i.origin_z);
        ax_d = '0;
        ay_d = '0;
      end
      OP_TO_GLOBAL: begin
        vx_d = VEC_W'(in_data_i.point_x);
        vy_d = VEC_W'(in_data_i.point_y);
        vz_d = VEC_W'(in_data_i.point_z) + VEC_W'(in_data_i.origin_z);
        ax_d = in_data_i.origin_x;
        ay_d = in_data_i.origin_y;
      end
      default: begin
        vx_d = '0;
        vy_d = '0;
        vz_d = '0;
        ax_d = '0;
        ay_d = '0;
      end
    endcase
  end

  pft_op_e                      s1_op_q;
  pft_trig_t                    s1_trig_q;
  logic signed [VEC_W-1:0]      s1_vx_q, s1_vy_q, s1_vz_q;
  logic signed [COORD_BITS-1:0] s1_ax_q, s1_ay_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_op_q   <= in_data_i.opcode;
      s1_trig_q <= trig;
      s1_vx_q   <= vx_d;
      s1_vy_q   <= vy_d;
      s1_vz_q   <= vz_d;
      s1_ax_q   <= ax_d;
      s1_ay_q   <= ay_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  pft_op_e                      s2_op_q;
  logic signed [P_W-1:0]        s2_xc_q, s2_xs_q, s2_yc_q, s2_ys_q;
  logic signed [VEC_W-1:0]      s2_vz_q;
  logic signed [COORD_BITS-1:0] s2_ax_q, s2_ay_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_op_q <= s1_op_q;
      s2_xc_q <= rmul(s1_vx_q, s1_trig_q.cos_v);
      s2_xs_q <= rmul(s1_vx_q, s1_trig_q.sin_v);
      s2_yc_q <= rmul(s1_vy_q, s1_trig_q.cos_v);
      s2_ys_q <= rmul(s1_vy_q, s1_trig_q.sin_v);
      s2_vz_q <= s1_vz_q;
      s2_ax_q <= s1_ax_q;
      s2_ay_q <= s1_ay_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [SUM_W-1:0] rx_d, ry_d;

  always_comb begin
    unique case (s2_op_q)
      OP_TO_VEHICLE: begin
        rx_d = SUM_W'(s2_xc_q) + SUM_W'(s2_ys_q);
        ry_d = SUM_W'(s2_yc_q) - SUM_W'(s2_xs_q);
      end
      OP_TO_GLOBAL: begin
        rx_d = SUM_W'(s2_xc_q) - SUM_W'(s2_ys_q) + SUM_W'(s2_ax_q);
        ry_d = SUM_W'(s2_xs_q) + SUM_W'(s2_yc_q) + SUM_W'(s2_ay_q);
      end
      default: begin
        rx_d = '0;
        ry_d = '0;
      end
    endcase
  end

  logic signed [SUM_W-1:0] s3_rx_q, s3_ry_q;
  logic signed [VEC_W-1:0] s3_rz_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_rx_q <= rx_d;
      s3_ry_q <= ry_d;
      s3_rz_q <= s2_vz_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [COORD_BITS:0] sat_x, sat_y, sat_z;
  pft_rsp_t            rsp_d;
  pft_rsp_t            rsp_q;

  always_comb begin
    sat_x          = saturate(s3_rx_q);
    sat_y          = saturate(s3_ry_q);
    sat_z          = saturate(SUM_W'(s3_rz_q));
    rsp_d.result_x = $signed(sat_x[COORD_BITS-1:0]);
    rsp_d.result_y = $signed(sat_y[COORD_BITS-1:0]);
    rsp_d.result_z = $signed(sat_z[COORD_BITS-1:0]);
    rsp_d.clipped  = sat_x[COORD_BITS] | sat_y[COORD_BITS] | sat_z[COORD_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en[STAGES-1]) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

`ifndef NO_ASSERTIONS
  // a stall at the input means every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // a clipped result has at least one coordinate at a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.result_x == SAT_MAX[COORD_BITS-1:0] ||
       out_data_o.result_x == SAT_MIN[COORD_BITS-1:0] ||
       out_data_o.result_y == SAT_MAX[COORD_BITS-1:0] ||
       out_data_o.result_y == SAT_MIN[COORD_BITS-1:0] ||
       out_data_o.result_z == SAT_MAX[COORD_BITS-1:0] ||
       out_data_o.result_z == SAT_MIN[COORD_BITS-1:0]))
    else $error("clip flag set without a saturated coordinate");

  // a request in the last inner stage reaches the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[STAGES-2] && en[STAGES-1]) |=> valid_q[STAGES-1])
    else $error("request lost between sums and output register");
`endif

endmodule
